// ===== rtl/core/iso8583_pkg.sv =====
// iso8583 message parser package: payload types, result kinds and field table
package iso8583_pkg;

  localparam int FIELD_COUNT = 128;
  localparam int MAP_BITS    = 128;
  localparam int TYPE_LEN    = 4;
  localparam int MAP_CHARS   = 32;
  localparam int TABLE_SIZE  = 10;

  localparam logic [2:0] KIND_TYPE     = 3'd0;
  localparam logic [2:0] KIND_FIELD    = 3'd1;
  localparam logic [2:0] KIND_COMPLETE = 3'd2;
  localparam logic [2:0] KIND_SHORT    = 3'd3;
  localparam logic [2:0] KIND_BAD_HEX  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] field_number;
    logic [7:0] char_value;
    logic [3:0] char_position;
    logic       field_end;
    logic [7:0] consumed;
    logic       run_last;
  } out_item_t;

  // fields that have a fixed length, in ascending order
  localparam logic [7:0] FIELD_IDS [TABLE_SIZE] = '{
    8'd2, 8'd3, 8'd4, 8'd7, 8'd11, 8'd12, 8'd37, 8'd41, 8'd49, 8'd128
  };

  function automatic logic [4:0] fixed_len(input logic [7:0] f);
    logic [4:0] len;
    case (f)
      8'd2:    len = 5'd16;
      8'd3:    len = 5'd6;
      8'd4:    len = 5'd12;
      8'd7:    len = 5'd10;
      8'd11:   len = 5'd6;
      8'd12:   len = 5'd6;
      8'd37:   len = 5'd12;
      8'd41:   len = 5'd8;
      8'd49:   len = 5'd3;
      8'd128:  len = 5'd16;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/iso8583_message_parser.sv =====
// iso8583 message parser top level: byte-serial type, bitmap and field slicer
//
//  channel | ports                             | carries
//  --------+-----------------------------------+---------------------------------
//  input   | in_valid, in_ready, in_data       | one message byte, end marker
//  output  | out_valid, out_ready, out_data    | type/field byte or end status
//
// one byte is taken per cycle while in_ready is high; its results are built by
// the state logic in the same cycle and land in a three-entry output queue.
// a type or field byte that also ends the buffer yields two results, the byte
// and the end status; input is taken while the queue has two free slots.
// rst_n (synchronous) returns the parser to the type phase and empties the queue.
// an end-of-buffer byte also returns the parser to the type phase.
module iso8583_message_parser
  import iso8583_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [1:0] {PH_TYPE, PH_MAP, PH_FIELDS, PH_DONE} phase_t;

  phase_t                phase_r, phase_nxt;
  logic [5:0]            pos_r, pos_nxt;
  logic [MAP_BITS-1:0]   map_r, map_nxt;
  logic [3:0]            nib_r, nib_nxt;
  logic [7:0]            field_r, field_nxt;
  logic [7:0]            cons_r, cons_nxt;
  logic                  hex_err_r, hex_err_nxt;

  out_item_t             slot_r [3];
  out_item_t             slot_nxt [3];
  logic [1:0]            cnt_r, cnt_nxt;

  logic                  accept, pop;
  logic                  has_byte;
  out_item_t             byte_res, stat_res, res_a, res_b;
  logic [1:0]            n_res;
  logic [4:0]            hex_v;
  logic [7:0]            full_byte;
  logic [4:0]            cur_len;
  logic                  fld_last;
  logic [1:0]            base;
  logic [1:0]            cnt_kept;

  // next present table field numbered above f, or 0 if there is none
  function automatic logic [7:0] next_field(input logic [7:0] f,
                                            input logic [MAP_BITS-1:0] m);
    logic [7:0] g;
    logic [7:0] id;
    logic [7:0] idx;
    g = 8'd0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      id  = FIELD_IDS[i];
      idx = id - 8'd1;
      if (m[idx[6:0]] && id > f && {24'd0, id} <= FIELD_COUNT) begin
        g = id;
      end
    end
    return g;
  endfunction

  // {bad, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    r = 5'b10000;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b0, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b0, d[3:0]};
    end
    return r;
  endfunction

  assign in_ready  = (cnt_r <= 2'd1);
  assign accept    = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot_r[0];
  assign pop       = out_valid && out_ready;

  assign hex_v     = hex_decode(in_data.data_byte);
  assign full_byte = {nib_r, hex_v[3:0]};
  assign cur_len   = fixed_len(field_r);
  assign fld_last  = ({1'b0, pos_r} + 7'd1) >= {2'b00, cur_len};

  // parser state update for one byte
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    map_nxt     = map_r;
    nib_nxt     = nib_r;
    field_nxt   = field_r;
    cons_nxt    = cons_r;
    hex_err_nxt = hex_err_r;
    has_byte    = 1'b0;
    byte_res    = '0;
    unique case (phase_r)
      PH_TYPE: begin
        has_byte               = 1'b1;
        byte_res.kind          = KIND_TYPE;
        byte_res.char_value    = in_data.data_byte;
        byte_res.char_position = pos_r[3:0];
        byte_res.field_end     = (pos_r == 6'(TYPE_LEN - 1));
        cons_nxt               = cons_r + 8'd1;
        if (pos_r == 6'(TYPE_LEN - 1)) begin
          phase_nxt = PH_MAP;
          pos_nxt   = 6'd0;
        end else begin
          pos_nxt = pos_r + 6'd1;
        end
      end
      PH_MAP: begin
        cons_nxt = cons_r + 8'd1;
        if (hex_v[4]) begin
          hex_err_nxt = 1'b1;
        end
        if (!pos_r[0]) begin
          nib_nxt = hex_v[3:0];
        end else begin
          // first character's msb is field 1
          for (int k = 0; k < 8; k++) begin
            if (full_byte[7-k]) begin
              map_nxt[{pos_r[4:1], 3'(k)}] = 1'b1;
            end
          end
        end
        if (pos_r == 6'(MAP_CHARS - 1)) begin
          pos_nxt   = 6'd0;
          field_nxt = next_field(8'd1, map_nxt);
          phase_nxt = (field_nxt != 8'd0) ? PH_FIELDS : PH_DONE;
        end else begin
          pos_nxt = pos_r + 6'd1;
        end
      end
      PH_FIELDS: begin
        has_byte               = 1'b1;
        byte_res.kind          = KIND_FIELD;
        byte_res.field_number  = field_r;
        byte_res.char_value    = in_data.data_byte;
        byte_res.char_position = pos_r[3:0];
        byte_res.field_end     = fld_last;
        cons_nxt               = cons_r + 8'd1;
        if (fld_last) begin
          pos_nxt   = 6'd0;
          field_nxt = next_field(field_r, map_r);
          if (field_nxt == 8'd0) begin
            phase_nxt = PH_DONE;
          end
        end else begin
          pos_nxt = pos_r + 6'd1;
        end
      end
      PH_DONE: begin
        // trailing bytes are ignored
      end
      default: begin
      end
    endcase
  end

  // end-of-buffer status and result ordering
  always_comb begin
    stat_res          = '0;
    stat_res.consumed = cons_nxt;
    stat_res.run_last = 1'b1;
    if (hex_err_nxt) begin
      stat_res.kind = KIND_BAD_HEX;
    end else if (phase_nxt != PH_DONE) begin
      stat_res.kind = KIND_SHORT;
    end else begin
      stat_res.kind = KIND_COMPLETE;
    end
    res_a = byte_res;
    res_b = stat_res;
    n_res = 2'd0;
    if (has_byte && in_data.end_of_buffer) begin
      n_res = 2'd2;
    end else if (has_byte) begin
      res_a.run_last = 1'b1;
      n_res          = 2'd1;
    end else if (in_data.end_of_buffer) begin
      res_a = stat_res;
      n_res = 2'd1;
    end
    if (!accept) begin
      n_res = 2'd0;
    end
  end

  // output queue: slot 0 is the head
  always_comb begin
    cnt_kept    = cnt_r - {1'b0, pop};
    base        = cnt_kept;
    slot_nxt[0] = pop ? slot_r[1] : slot_r[0];
    slot_nxt[1] = pop ? slot_r[2] : slot_r[1];
    slot_nxt[2] = slot_r[2];
    for (int j = 0; j < 3; j++) begin
      if (n_res != 2'd0 && 2'(j) == base) begin
        slot_nxt[j] = res_a;
      end
      if (n_res == 2'd2 && 2'(j) == base + 2'd1) begin
        slot_nxt[j] = res_b;
      end
    end
    cnt_nxt = cnt_kept + n_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TYPE;
      pos_r     <= '0;
      map_r     <= '0;
      nib_r     <= '0;
      field_r   <= '0;
      cons_r    <= '0;
      hex_err_r <= 1'b0;
      cnt_r     <= '0;
      for (int j = 0; j < 3; j++) begin
        slot_r[j] <= '0;
      end
    end else begin
      cnt_r <= cnt_nxt;
      for (int j = 0; j < 3; j++) begin
        slot_r[j] <= slot_nxt[j];
      end
      if (accept) begin
        if (in_data.end_of_buffer) begin
          phase_r   <= PH_TYPE;
          pos_r     <= '0;
          map_r     <= '0;
          nib_r     <= '0;
          field_r   <= '0;
          cons_r    <= '0;
          hex_err_r <= 1'b0;
        end else begin
          phase_r   <= phase_nxt;
          pos_r     <= pos_nxt;
          map_r     <= map_nxt;
          nib_r     <= nib_nxt;
          field_r   <= field_nxt;
          cons_r    <= cons_nxt;
          hex_err_r <= hex_err_nxt;
        end
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd3)
    else $error("output queue overflow");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.end_of_buffer |=> phase_r == PH_TYPE && cons_r == 8'd0)
    else $error("parser not reset after end of buffer");

  a_field_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FIELDS |-> fixed_len(field_r) != 5'd0 && pos_r < 6'd16)
    else $error("slicing a field with no length");

  a_type_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TYPE |-> pos_r < 6'(TYPE_LEN))
    else $error("type position out of range");

  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_COMPLETE || out_data.kind == KIND_SHORT ||
                  out_data.kind == KIND_BAD_HEX)
      |-> out_data.field_number == 8'd0 && out_data.run_last)
    else $error("malformed status item");

endmodule
